>>> rtl/mtfr_pkg.sv
// Shared constants, token type and helper for the move-to-front rank encoder.
package mtfr_pkg;

    localparam int MAX_ITEMS  = 256;
    localparam int ITEM_W     = $clog2(MAX_ITEMS);
    localparam int COUNT_W    = 9;
    localparam int RANK_W     = 8;
    localparam int IN_TDATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);
    localparam logic               CMD_LOOKUP  = 1'b0;
    localparam logic               CMD_RESTART = 1'b1;

    // One request as it walks down the row of cells
    typedef struct packed {
        logic              valid;
        logic              restart;
        logic              err;
        logic              found;
        logic [ITEM_W-1:0] want;
        logic [ITEM_W-1:0] carry;
        logic [RANK_W-1:0] rank;
    } mtfr_tok_t;

    function automatic logic [RANK_W-1:0] sat_rank(input logic [ITEM_W-1:0] idx);
        logic [RANK_W-1:0] r;
        if (32'(idx) > 32'((1 << RANK_W) - 1))
        begin
            r = '1;
        end
        else
        begin
            r = RANK_W'(idx);
        end
        return r;
    endfunction

endpackage

>>> rtl/mtfr_cell.sv
// One list position: holds one entry and swaps it with a passing lookup.
module mtfr_cell
    import mtfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [ITEM_W-1:0] index,
    input  mtfr_tok_t         tok_in,
    output mtfr_tok_t         tok_out
);

    logic [ITEM_W-1:0] entry_reg;
    logic [ITEM_W-1:0] entry_next;
    mtfr_tok_t         tok_reg;
    mtfr_tok_t         tok_next;
    logic              active;
    logic              hit;

    // a lookup still searching for its item
    assign active = tok_in.valid && !tok_in.restart && !tok_in.err && !tok_in.found;
    assign hit    = active && (entry_reg == tok_in.want);

    always_comb
    begin
        entry_next = entry_reg;
        tok_next   = tok_in;
        if (tok_in.valid && tok_in.restart)
        begin
            entry_next = index;
        end
        else if (active)
        begin
            // take the entry shifted down from ahead, hand ours onward
            entry_next     = tok_in.carry;
            tok_next.carry = entry_reg;
            if (hit)
            begin
                tok_next.found = 1'b1;
                tok_next.rank  = sat_rank(index);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= index;
            tok_reg   <= '0;
        end
        else if (advance)
        begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/move_to_front_rank.sv
// Top level of the move-to-front rank encoder: input check, cell row, output.
//
// Requests enter on the s_ stream: s_tuser is the command (0 lookup and move
// to front, 1 restart identity order), s_tdata[8:0] the 1-based item.
// Results leave on the m_ stream: m_tdata is the rank (items ahead of the
// item before the move), m_tuser the error flag (item 0 or above item_count
// or MAX_ITEMS, list unchanged). Restart/error results carry rank 0. The user
// writes item_count via cfg_we/cfg_data while the block is idle; not checked.
//
// The list lives in a row of MAX_ITEMS cells, one entry each. A request walks
// the row one cell per cycle unless the row is held, swapping entries until
// it meets its item. Each cell registers the request; m_tvalid rises when it
// reaches the last cell. Requests follow each other in consecutive cycles:
// one request per cycle sustained while the output is not stalled.
// The last cell's register is the output register. While m_tvalid is high and
// m_tready low the whole row holds and s_tready is low.
// Reset restores identity order and item_count = 256 at once; no clearing pass.
module move_to_front_rank
    import mtfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_data,     // item_count
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,      // [8:0] item
    input  logic                  s_tuser,      // [0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [RANK_W-1:0]     m_tdata,      // [7:0] rank
    output logic                  m_tuser       // [0] error
);

    logic [COUNT_W-1:0] item_count_reg;
    logic [COUNT_W-1:0] item;
    logic               advance;
    logic               item_ok;
    mtfr_tok_t          chain [MAX_ITEMS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            item_count_reg <= cfg_data;
        end
    end

    assign item    = s_tdata[COUNT_W-1:0];
    assign advance = !chain[MAX_ITEMS].valid || m_tready;
    assign s_tready = advance;

    assign item_ok = (item != '0) && (item <= item_count_reg)
                  && (32'(item) <= 32'(MAX_ITEMS));

    always_comb
    begin
        chain[0]         = '0;
        chain[0].valid   = s_tvalid;
        chain[0].restart = (s_tuser == CMD_RESTART);
        chain[0].err     = (s_tuser == CMD_LOOKUP) && !item_ok;
        chain[0].want    = ITEM_W'(item - COUNT_W'(1));
        chain[0].carry   = ITEM_W'(item - COUNT_W'(1));
    end

    for (genvar k = 0; k < MAX_ITEMS; k++)
    begin : g_cell
        mtfr_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .index   (ITEM_W'(k)),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    assign m_tvalid = chain[MAX_ITEMS].valid;
    assign m_tdata  = chain[MAX_ITEMS].rank;
    assign m_tuser  = chain[MAX_ITEMS].err;

    // a lookup in range always meets its item somewhere in the row
    a_lookup_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !chain[MAX_ITEMS].restart && !chain[MAX_ITEMS].err
        |-> chain[MAX_ITEMS].found)
        else $error("lookup left the row without finding its item");

    a_err_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser || chain[MAX_ITEMS].restart) |-> (m_tdata == '0))
        else $error("error or restart result with nonzero rank");

    a_err_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser || chain[MAX_ITEMS].restart)
        |-> !chain[MAX_ITEMS].found)
        else $error("error or restart request touched the list");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> !s_tready || m_tready)
        else $error("row advanced while output stalled");

endmodule

>>> test/move_to_front_rank_test.sv
// Self-checking testbench for the move-to-front rank encoder.
module move_to_front_rank_test;
    import mtfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = MAX_ITEMS + 64;
    localparam int PHASE_ITEMS    = 165;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              error;
    } rank_result_t;

    // Tracks the list order and holds the ranks still owed by the block
    class mtf_rank_scoreboard;
        logic [ITEM_W-1:0]  list_model [MAX_ITEMS];
        logic [COUNT_W-1:0] item_count;
        rank_result_t       expected_ranks [$];
        int                 fails;

        function new();
            item_count = COUNT_RESET;
            fails      = 0;
            restart_order();
        endfunction

        function void restart_order();
            for (int k = 0; k < MAX_ITEMS; k++)
            begin
                list_model[k] = ITEM_W'(k);
            end
        endfunction

        function int pending();
            return expected_ranks.size();
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            fails++;
        endtask

        function void note_request(input logic cmd, input logic [COUNT_W-1:0] item);
            int                limit;
            int                pos;
            logic [ITEM_W-1:0] want;
            rank_result_t      res;
            limit = (int'(item_count) > MAX_ITEMS) ? MAX_ITEMS : int'(item_count);
            res   = '0;
            pos   = 0;
            want  = ITEM_W'(int'(item) - 1);
            if (cmd == CMD_RESTART)
            begin
                restart_order();
            end
            else if (item == 0 || int'(item) > limit)
            begin
                res.error = 1'b1;
            end
            else
            begin
                for (int k = 0; k < MAX_ITEMS; k++)
                begin
                    if (list_model[k] == want)
                    begin
                        pos = k;
                        break;
                    end
                end
                for (int k = pos; k > 0; k--)
                begin
                    list_model[k] = list_model[k-1];
                end
                list_model[0] = want;
                res.rank = (pos > 255) ? '1 : RANK_W'(pos);
            end
            expected_ranks.push_back(res);
        endfunction

        task check_result(input logic [RANK_W-1:0] rank, input logic error);
            rank_result_t exp_res;
            if (expected_ranks.size() == 0)
            begin
                report_mismatch($sformatf("result rank=%0d error=%0b with no request pending",
                                          rank, error));
            end
            else
            begin
                exp_res = expected_ranks.pop_front();
                if (rank !== exp_res.rank)
                begin
                    report_mismatch($sformatf("rank %0d, expected %0d", rank, exp_res.rank));
                end
                if (error !== exp_res.error)
                begin
                    report_mismatch($sformatf("error %0b, expected %0b", error, exp_res.error));
                end
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [COUNT_W-1:0]    cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [RANK_W-1:0]     m_tdata;
    logic                  m_tuser;

    mtf_rank_scoreboard board;
    logic               steady;       // both sides run without gaps while set
    int                 quiet_cycles;

    move_to_front_rank i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side back-pressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_result(m_tdata, m_tuser);
        end
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called at a falling edge; returns at a falling edge
    task automatic send_request(input logic cmd, input logic [COUNT_W-1:0] item);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= IN_TDATA_W'(item);
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(cmd, item);
        @(negedge clk);
    endtask

    task automatic lookup(input logic [COUNT_W-1:0] item);
        send_request(CMD_LOOKUP, item);
    endtask

    // Every request yields a result, so an empty queue means the row is empty
    task automatic write_item_count(input logic [COUNT_W-1:0] value);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        board.item_count = value;
    endtask

    // Small items keep recently used entries near the front
    function automatic logic [COUNT_W-1:0] pick_item(input int lim);
        int roll;
        roll = $urandom_range(0, 99);
        if (lim == 0 || roll < 8)
        begin
            return COUNT_W'($urandom_range(0, 511));
        end
        else if (roll < 12)
        begin
            return '0;
        end
        else if (roll < 17)
        begin
            return COUNT_W'($urandom_range(lim + 1, 511));
        end
        else if (roll < 60)
        begin
            return COUNT_W'($urandom_range(1, (lim < 8) ? lim : 8));
        end
        return COUNT_W'($urandom_range(1, lim));
    endfunction

    task automatic random_phase(input logic [COUNT_W-1:0] count);
        int lim;
        write_item_count(count);
        lim = (int'(count) > MAX_ITEMS) ? MAX_ITEMS : int'(count);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                send_request(CMD_RESTART, COUNT_W'($urandom_range(0, 511)));
            end
            else
            begin
                send_request(CMD_LOOKUP, pick_item(lim));
            end
        end
    endtask

    initial
    begin
        logic [COUNT_W-1:0] phase_counts [11];
        board        = new();
        steady       = 1'b0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_LOOKUP;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset count, ends of the list, out-of-range items
        send_request(CMD_RESTART, 9'd511);
        lookup(9'd1);
        lookup(9'd256);
        lookup(9'd256);
        lookup(9'd1);
        lookup(9'd128);
        lookup(9'd0);
        lookup(9'd257);
        lookup(9'd511);
        // Count shrunk without restart: items above the count still count as ahead
        write_item_count(9'd2);
        lookup(9'd2);
        lookup(9'd3);
        lookup(9'd1);
        lookup(9'd256);
        write_item_count(9'd1);
        lookup(9'd1);
        lookup(9'd2);
        write_item_count(9'd0);
        lookup(9'd1);
        write_item_count(9'd511);
        lookup(9'd256);
        lookup(9'd257);
        lookup(9'd511);
        send_request(CMD_RESTART, 9'd0);
        lookup(9'd200);

        phase_counts = '{9'd256, 9'd1, 9'd3, 9'd0, 9'd511, 9'd300, 9'd257, 9'd64,
                         COUNT_W'($urandom_range(1, 256)), COUNT_W'($urandom_range(0, 511)),
                         9'd256};
        foreach (phase_counts[p])
        begin
            steady = (p == 5);
            random_phase(phase_counts[p]);
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.fails == 0 && board.pending() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/mtfr_pkg.sv
rtl/mtfr_cell.sv
rtl/move_to_front_rank.sv
test/move_to_front_rank_test.sv
